// ===== rtl/core/rgb_to_planar_yuv_converter_assert.svh =====
// Assertion macros shared by the converter RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef RGB_TO_PLANAR_YUV_CONVERTER_ASSERT_SVH
`define RGB_TO_PLANAR_YUV_CONVERTER_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define RYUV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("RYUV assertion failed");

// Condition that must never be true outside reset.
`define RYUV_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("RYUV forbidden condition seen");

`else

`define RYUV_ASSERT(label, clk, rst_n, prop)
`define RYUV_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== rtl/core/ryuv_pkg.sv =====
// Shared types and constants for the RGB to planar YUV converter.
// No dependencies; imported by every module of the block.
package ryuv_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int IDX_W      = 24;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  // Frame dimensions after clamping, wide enough for the largest allowed maximum.
  localparam int DIM_W      = 15;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_MODE  = CFG_IDX_W'(2);

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = CFG_DATA_W'(640);
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = CFG_DATA_W'(480);

  localparam logic CHROMA_444 = 1'b0;
  localparam logic CHROMA_420 = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } ryuv_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [IDX_W-1:0] luma_index;
    logic             chroma_write;
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] chroma_v;
    logic [IDX_W-1:0] chroma_index;
    logic             frame_last;
  } ryuv_out_t;

  // Plane positions of one pixel, taken when its request is accepted.
  typedef struct packed {
    logic [IDX_W-1:0] luma_index;
    logic             chroma_write;
    logic [IDX_W-1:0] chroma_index;
    logic             frame_last;
  } ryuv_pos_t;

endpackage

// ===== rtl/core/rgb_to_planar_yuv_converter.sv =====
// RGB to planar YUV converter: one pixel request in, one plane write result out.
// Each request is registered in the input register, and its result then in the output register.
// Throughput: one pixel per clock while out_stall is low; the input register and the output
// register each hold one request, so one more request is taken while a result waits.
// Reset clears the raster counters and both pipeline stages and restores the
// registers to 640 x 480 with full-resolution chroma.
`include "rgb_to_planar_yuv_converter_assert.svh"

module rgb_to_planar_yuv_converter #(
  parameter int MAX_WIDTH  = ryuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ryuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ryuv_pkg::ryuv_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ryuv_pkg::ryuv_out_t             out_data,
  input  logic                            cfg_wr_en,
  input  logic [ryuv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
  import ryuv_pkg::*;

  logic [CFG_DATA_W-1:0] image_width_r, image_height_r;
  logic                  chroma_mode_r;

  logic       s1_valid_r;
  ryuv_in_t   s1_pixel_r;
  ryuv_pos_t  s1_pos_r;
  logic       out_valid_r;
  ryuv_out_t  out_data_r;

  ryuv_pos_t        pos;
  logic             s1_ready, s2_ready, in_accept, s1_move;
  logic [PIX_W-1:0] luma, chroma_u, chroma_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      chroma_mode_r  <= CHROMA_444;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wr_data;
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wr_data;
        REG_CHROMA_MODE:  chroma_mode_r  <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign s1_move   = s1_valid_r && s2_ready;
  assign in_accept = in_valid && s1_ready;
  assign in_stall  = !s1_ready;

  ryuv_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_position (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_accept),
    .image_width  (image_width_r),
    .image_height (image_height_r),
    .chroma_mode  (chroma_mode_r),
    .pos          (pos)
  );

  ryuv_color u_color (
    .pixel        (s1_pixel_r),
    .chroma_write (s1_pos_r.chroma_write),
    .luma         (luma),
    .chroma_u     (chroma_u),
    .chroma_v     (chroma_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pixel_r <= in_data;
      s1_pos_r   <= pos;
    end
    if (s1_move) begin
      out_data_r.luma         <= luma;
      out_data_r.luma_index   <= s1_pos_r.luma_index;
      out_data_r.chroma_write <= s1_pos_r.chroma_write;
      out_data_r.chroma_u     <= chroma_u;
      out_data_r.chroma_v     <= chroma_v;
      out_data_r.chroma_index <= s1_pos_r.chroma_index;
      out_data_r.frame_last   <= s1_pos_r.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RYUV_ASSERT(a_s1_holds, clk, rst_n, (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_pos_r)))
  `RYUV_ASSERT(a_s1_to_out, clk, rst_n, s1_move |=> (out_valid_r && out_data_r.luma_index == $past(s1_pos_r.luma_index)))
  `RYUV_ASSERT(a_mode_write, clk, rst_n, (cfg_wr_en && cfg_index == REG_CHROMA_MODE) |=> (chroma_mode_r == $past(cfg_wr_data[0])))
  `RYUV_ASSERT_NEVER(a_no_chroma_leak, clk, rst_n, out_valid_r && !out_data_r.chroma_write && (out_data_r.chroma_u != '0 || out_data_r.chroma_v != '0 || out_data_r.chroma_index != '0))

endmodule

// ===== rtl/core/ryuv_position.sv =====
// Raster position tracker: column, row, luma and chroma plane indexes.
// Depends on ryuv_pkg and the assertion macro header.
`include "rgb_to_planar_yuv_converter_assert.svh"

module ryuv_position #(
  parameter int MAX_WIDTH  = ryuv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ryuv_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0] image_width,
  input  logic [ryuv_pkg::CFG_DATA_W-1:0] image_height,
  input  logic                            chroma_mode,
  output ryuv_pkg::ryuv_pos_t             pos
);
  import ryuv_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [DIM_W-1:0] WidthCap     = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] WidthCapEven = DIM_W'((MAX_WIDTH / 2) * 2);
  localparam logic [DIM_W-1:0] HeightCap    = DIM_W'(MAX_HEIGHT);

  logic [COL_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_W-1:0] row_count_r, row_count_nxt;
  logic [IDX_W-1:0] luma_position_r, luma_position_nxt;
  logic [IDX_W-1:0] chroma_row_base_r, chroma_row_base_nxt;

  logic [DIM_W-1:0] width_even;
  logic [DIM_W-1:0] eff_width;
  logic [DIM_W-1:0] height_raw;
  logic [DIM_W-1:0] eff_height;
  logic [DIM_W-1:0] column_plus;
  logic [DIM_W-1:0] row_plus;
  logic             row_end;
  logic             frame_end;

  // Odd widths round down to even; both dimensions are clamped to their legal range.
  always_comb begin
    width_even = DIM_W'({image_width[CFG_DATA_W-1:1], 1'b0});
    height_raw = DIM_W'(image_height);
    priority if (width_even < DIM_W'(2)) begin
      eff_width = DIM_W'(2);
    end else if (width_even > WidthCap) begin
      eff_width = WidthCapEven;
    end else begin
      eff_width = width_even;
    end
    priority if (height_raw < DIM_W'(1)) begin
      eff_height = DIM_W'(1);
    end else if (height_raw > HeightCap) begin
      eff_height = HeightCap;
    end else begin
      eff_height = height_raw;
    end
  end

  assign column_plus = DIM_W'(column_count_r) + DIM_W'(1);
  assign row_plus    = DIM_W'(row_count_r) + DIM_W'(1);
  // A column or row already past a shrunken dimension also ends the row or frame.
  assign row_end     = column_plus >= eff_width;
  assign frame_end   = row_end && (row_plus >= eff_height);

  always_comb begin
    pos.luma_index = luma_position_r;
    pos.frame_last = frame_end;
    if (chroma_mode == CHROMA_444) begin
      pos.chroma_write = 1'b1;
      pos.chroma_index = luma_position_r;
    end else begin
      pos.chroma_write = column_count_r[0];
      pos.chroma_index = column_count_r[0] ?
        (chroma_row_base_r + IDX_W'(column_count_r >> 1)) : '0;
    end
  end

  always_comb begin
    column_count_nxt    = column_count_r;
    row_count_nxt       = row_count_r;
    luma_position_nxt   = luma_position_r;
    chroma_row_base_nxt = chroma_row_base_r;
    if (advance) begin
      if (frame_end) begin
        column_count_nxt    = '0;
        row_count_nxt       = '0;
        luma_position_nxt   = '0;
        chroma_row_base_nxt = '0;
      end else begin
        luma_position_nxt = luma_position_r + IDX_W'(1);
        if (row_end) begin
          column_count_nxt = '0;
          row_count_nxt    = ROW_W'(row_plus);
          // The chroma row moves on only after the odd row of each pair.
          if (row_count_r[0]) begin
            chroma_row_base_nxt = chroma_row_base_r + IDX_W'(eff_width >> 1);
          end
        end else begin
          column_count_nxt = COL_W'(column_plus);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r    <= '0;
      row_count_r       <= '0;
      luma_position_r   <= '0;
      chroma_row_base_r <= '0;
    end else begin
      column_count_r    <= column_count_nxt;
      row_count_r       <= row_count_nxt;
      luma_position_r   <= luma_position_nxt;
      chroma_row_base_r <= chroma_row_base_nxt;
    end
  end

  `RYUV_ASSERT(a_frame_restart, clk, rst_n, (advance && pos.frame_last) |=> (column_count_r == '0 && row_count_r == '0 && luma_position_r == '0 && chroma_row_base_r == '0))
  `RYUV_ASSERT(a_luma_step, clk, rst_n, (advance && !pos.frame_last) |=> (luma_position_r == IDX_W'($past(luma_position_r) + IDX_W'(1))))
  `RYUV_ASSERT_NEVER(a_full_chroma_writes, clk, rst_n, (chroma_mode == CHROMA_444) && !pos.chroma_write)

endmodule

// ===== rtl/core/ryuv_color.sv =====
// Color matrix: Q10 weighted sums for Y, U and V with floor, offset and saturation.
// Depends on ryuv_pkg.
module ryuv_color (
  input  ryuv_pkg::ryuv_in_t          pixel,
  input  logic                        chroma_write,
  output logic [ryuv_pkg::PIX_W-1:0]  luma,
  output logic [ryuv_pkg::PIX_W-1:0]  chroma_u,
  output logic [ryuv_pkg::PIX_W-1:0]  chroma_v
);
  import ryuv_pkg::*;

  localparam int SUM_W  = 21;
  localparam int FRAC_W = 10;
  localparam int Q_W    = SUM_W - FRAC_W;
  localparam int T_W    = Q_W + 1;

  localparam logic signed [SUM_W-1:0] CoefYR = SUM_W'(306);
  localparam logic signed [SUM_W-1:0] CoefYG = SUM_W'(601);
  localparam logic signed [SUM_W-1:0] CoefYB = SUM_W'(117);
  // U leans on red and V on blue, the reverse of the textbook matrix.
  localparam logic signed [SUM_W-1:0] CoefUR = SUM_W'(450);
  localparam logic signed [SUM_W-1:0] CoefUG = -SUM_W'(377);
  localparam logic signed [SUM_W-1:0] CoefUB = -SUM_W'(73);
  localparam logic signed [SUM_W-1:0] CoefVR = -SUM_W'(152);
  localparam logic signed [SUM_W-1:0] CoefVG = -SUM_W'(298);
  localparam logic signed [SUM_W-1:0] CoefVB = SUM_W'(450);
  localparam logic signed [T_W-1:0]   OffLuma   = T_W'(16);
  localparam logic signed [T_W-1:0]   OffChroma = T_W'(128);

  logic signed [SUM_W-1:0] red_s, green_s, blue_s;
  logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
  logic [PIX_W-1:0]        u_sat, v_sat;

  // Arithmetic shift floors toward minus infinity, then the offset and clamp follow.
  function automatic logic [PIX_W-1:0] finish(input logic signed [SUM_W-1:0] sum,
                                              input logic signed [T_W-1:0] offset);
    logic signed [Q_W-1:0] q;
    logic signed [T_W-1:0] t;
    q = $signed(sum[SUM_W-1:FRAC_W]);
    t = T_W'(q) + offset;
    if (t < 0) begin
      finish = '0;
    end else if (t > T_W'(255)) begin
      finish = '1;
    end else begin
      finish = t[PIX_W-1:0];
    end
  endfunction

  assign red_s   = SUM_W'(pixel.red);
  assign green_s = SUM_W'(pixel.green);
  assign blue_s  = SUM_W'(pixel.blue);

  assign y_sum = CoefYR * red_s + CoefYG * green_s + CoefYB * blue_s;
  assign u_sum = CoefUR * red_s + CoefUG * green_s + CoefUB * blue_s;
  assign v_sum = CoefVR * red_s + CoefVG * green_s + CoefVB * blue_s;

  assign luma     = finish(y_sum, OffLuma);
  assign u_sat    = finish(u_sum, OffChroma);
  assign v_sat    = finish(v_sum, OffChroma);
  assign chroma_u = chroma_write ? u_sat : '0;
  assign chroma_v = chroma_write ? v_sat : '0;

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for rgb_to_planar_yuv_converter: pixel requests in,
// plane writes out, compared against an in-bench Q10 color and raster predictor.
// Depends on ryuv_pkg and the converter RTL only.
`timescale 1ns / 100ps

module tb;
  import ryuv_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 950;
  localparam int PAUSE_AT      = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;

  // Q10 weights of the converter.
  localparam int KY_R = 306;
  localparam int KY_G = 601;
  localparam int KY_B = 117;
  localparam int KU_R = 450;
  localparam int KU_G = -377;
  localparam int KU_B = -73;
  localparam int KV_R = -152;
  localparam int KV_G = -298;
  localparam int KV_B = 450;
  localparam int Y_OFFSET = 16;
  localparam int C_OFFSET = 128;

  localparam logic ROW_PIXEL = 1'b0;
  localparam logic ROW_REG   = 1'b1;

  typedef struct packed {
    logic       typed;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } golden_t;

  typedef struct packed {
    logic                  kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    ryuv_in_t              pix;
    golden_t               gold;
  } step_t;

  localparam golden_t NO_GOLD = '0;
  localparam int DIRECTED_ROWS = 33;

  // Register fields are unused on pixel rows.
  localparam step_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h000000, 1'b1, 8'd16,  8'd128, 8'd128},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, 1'b1, 8'd255, 8'd128, 8'd128},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFF0000, 1'b1, 8'd92,  8'd240, 8'd90},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h00FF00, 1'b1, 8'd165, 8'd34,  8'd53},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h0000FF, 1'b1, 8'd45,  8'd109, 8'd240},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFF00FF, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h00FFFF, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFFFF00, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h55AA55, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hAA55AA, NO_GOLD},
    // Odd width and zero height, changed in the middle of a row.
    {ROW_REG, REG_IMAGE_WIDTH,  13'd3,             24'h0, NO_GOLD},
    {ROW_REG, REG_IMAGE_HEIGHT, 13'd0,             24'h0, NO_GOLD},
    {ROW_REG, REG_CHROMA_MODE,  13'(CHROMA_420),   24'h0, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h808080, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h010203, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFEFDFC, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h7F807F, NO_GOLD},
    // Width below the minimum and height above the maximum.
    {ROW_REG, REG_IMAGE_WIDTH,  13'd1,             24'h0, NO_GOLD},
    {ROW_REG, REG_IMAGE_HEIGHT, 13'd5000,          24'h0, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h123456, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h654321, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h0F0F0F, NO_GOLD},
    // Width above the maximum.
    {ROW_REG, REG_IMAGE_WIDTH,  13'h1FFF,          24'h0, NO_GOLD},
    {ROW_REG, REG_IMAGE_HEIGHT, 13'd2,             24'h0, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hF0F0F0, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h3C3C3C, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hC3C3C3, NO_GOLD},
    {ROW_REG, REG_IMAGE_WIDTH,  13'd6,             24'h0, NO_GOLD},
    {ROW_REG, REG_IMAGE_HEIGHT, 13'd3,             24'h0, NO_GOLD},
    {ROW_REG, REG_CHROMA_MODE,  13'(CHROMA_444),   24'h0, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h000000, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'hFFFFFF, NO_GOLD},
    {ROW_PIXEL, REG_IMAGE_WIDTH, 13'd0, 24'h808000, NO_GOLD}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  ryuv_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  ryuv_out_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

  golden_t   in_golden = '0;
  ryuv_out_t yuv_pending [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        send_calm = 1'b0;
  bit        recv_calm = 1'b0;
  int        stall_left = 0;

  // Mirror of the registers and raster counters.
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic                  mode_reg;
  int                    col_cnt;
  int                    row_cnt;
  int                    luma_pos;
  int                    chroma_base;

  rgb_to_planar_yuv_converter u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [7:0] sat_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] draw_component();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Predicts the plane write for every accepted pixel request.
  always @(posedge clk) begin : convert_pixel
    int        w, h, r, g, b, cu, cv, cidx;
    logic      row_end, last, cw;
    ryuv_out_t res;
    if (!rst_n) begin
      width_reg   = RST_IMAGE_WIDTH;
      height_reg  = RST_IMAGE_HEIGHT;
      mode_reg    = CHROMA_444;
      col_cnt     = 0;
      row_cnt     = 0;
      luma_pos    = 0;
      chroma_base = 0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_reg = cfg_wr_data;
        REG_IMAGE_HEIGHT: height_reg = cfg_wr_data;
        REG_CHROMA_MODE:  mode_reg = cfg_wr_data[0];
        default: ;
      endcase
    end else if (in_valid && !in_stall) begin
      w = int'(width_reg) & ~1;
      if (w < 2) w = 2;
      if (w > MAX_W) w = MAX_W & ~1;
      h = int'(height_reg);
      if (h < 1) h = 1;
      if (h > MAX_H) h = MAX_H;
      row_end = (col_cnt + 1 >= w);
      last = row_end && (row_cnt + 1 >= h);
      r = int'(in_data.red);
      g = int'(in_data.green);
      b = int'(in_data.blue);
      // Arithmetic shift of a signed sum floors toward minus infinity.
      res.luma = sat_byte(((KY_R * r + KY_G * g + KY_B * b) >>> 10) + Y_OFFSET);
      cu = ((KU_R * r + KU_G * g + KU_B * b) >>> 10) + C_OFFSET;
      cv = ((KV_R * r + KV_G * g + KV_B * b) >>> 10) + C_OFFSET;
      if (mode_reg == CHROMA_444) begin
        cw = 1'b1;
        cidx = luma_pos;
      end else begin
        cw = col_cnt[0];
        cidx = chroma_base + (col_cnt >> 1);
      end
      res.luma_index   = luma_pos[IDX_W-1:0];
      res.chroma_write = cw;
      res.chroma_u     = cw ? sat_byte(cu) : 8'd0;
      res.chroma_v     = cw ? sat_byte(cv) : 8'd0;
      res.chroma_index = cw ? cidx[IDX_W-1:0] : '0;
      res.frame_last   = last;
      if (in_golden.typed) begin
        res.luma     = in_golden.y;
        res.chroma_u = in_golden.u;
        res.chroma_v = in_golden.v;
      end
      yuv_pending.push_back(res);

      if (last) begin
        col_cnt     = 0;
        row_cnt     = 0;
        luma_pos    = 0;
        chroma_base = 0;
      end else begin
        luma_pos = (luma_pos + 1) & 32'hFFFFFF;
        if (row_end) begin
          col_cnt = 0;
          row_cnt = row_cnt + 1;
          if (row_cnt[0] == 1'b0) chroma_base = (chroma_base + (w >> 1)) & 32'hFFFFFF;
        end else begin
          col_cnt = col_cnt + 1;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Checks each accepted plane write and draws the next stall of the result side.
  always @(posedge clk) begin : result_check
    int unsigned hold;
    ryuv_out_t   want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      if (yuv_pending.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = yuv_pending.pop_front();
        check_field("luma", want.luma, out_data.luma);
        check_field("luma_index", want.luma_index, out_data.luma_index);
        check_field("chroma_write", want.chroma_write, out_data.chroma_write);
        check_field("chroma_u", want.chroma_u, out_data.chroma_u);
        check_field("chroma_v", want.chroma_v, out_data.chroma_v);
        check_field("chroma_index", want.chroma_index, out_data.chroma_index);
        check_field("frame_last", want.frame_last, out_data.frame_last);
      end
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      hold = recv_calm ? 0 : $urandom_range(0, 8);
      out_stall <= (hold != 0);
      stall_left = hold;
    end else if (stall_left > 1) begin
      stall_left = stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(input ryuv_in_t px, input golden_t gold);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    cfg_wr_en <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= px;
    in_golden <= gold;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
  endtask

  // The extra edge lets the predictor record the request accepted last.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (yuv_pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    int                    sent;
    int                    phase_len;
    bit                    prev_reg;
    bit                    pause_done;
    logic [CFG_DATA_W-1:0] wval, hval;
    ryuv_in_t              px;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    prev_reg = 1'b0;
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED_STEPS[i].kind == ROW_REG) begin
        if (!prev_reg) wait_for_results();
        write_reg(DIRECTED_STEPS[i].reg_idx, DIRECTED_STEPS[i].reg_val);
        prev_reg = 1'b1;
      end else begin
        send_pixel(DIRECTED_STEPS[i].pix, DIRECTED_STEPS[i].gold);
        prev_reg = 1'b0;
      end
    end

    sent = 0;
    pause_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      wait_for_results();
      case ($urandom_range(0, 15))
        0:       wval = 13'd0;
        1:       wval = 13'd1;
        2:       wval = 13'd4096;
        3:       wval = 13'h1FFF;
        4:       wval = 13'($urandom_range(2, 4096));
        default: wval = 13'($urandom_range(2, 16));
      endcase
      case ($urandom_range(0, 15))
        0:       hval = 13'd0;
        1:       hval = 13'd4096;
        2:       hval = 13'h1FFF;
        3:       hval = 13'($urandom_range(1, 4096));
        default: hval = 13'($urandom_range(1, 6));
      endcase
      write_reg(REG_IMAGE_WIDTH, wval);
      write_reg(REG_IMAGE_HEIGHT, hval);
      write_reg(REG_CHROMA_MODE, ($urandom_range(0, 1) != 0) ? 13'(CHROMA_420)
                                                             : 13'(CHROMA_444));
      send_calm = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 90);
      for (int k = 0; k < phase_len; k++) begin
        if (!pause_done && sent >= PAUSE_AT) begin
          wait_for_results();
          pause_done = 1'b1;
        end
        px.red   = draw_component();
        px.green = draw_component();
        px.blue  = draw_component();
        send_pixel(px, NO_GOLD);
        sent++;
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
